/* design/pli_pkg.sv */
// shared types and constants for the positional list insert/delete block
// no dependencies; used by pli_seq and positional_list_insert_delete
package pli_pkg;

  // default geometry of the list store
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int ELEM_WIDTH_DEF  = 32;

  // fixed port widths
  localparam int POS_W    = 7;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // one finished result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   removed;
    logic [COUNT_W-1:0]  count;
  } res_t;

endpackage

/* design/positional_list_insert_delete.sv */
// top level of the positional list: sequencer, entry store and result register
// depends on pli_pkg, pli_mem and pli_seq
//
// Usage:
//   Request channel (req_valid / req_stall) carries op, position and payload.
//   An insert at one-based position p opens a gap at p and stores the word;
//   a delete at p returns the word there and closes the gap. Refused
//   requests (full list, bad position) leave the list unchanged.
//   Response channel (rsp_valid / rsp_stall) carries status, removed and
//   count, exactly one word per request, in request order.
// Shifting:
//   The list lives in a single-port-read, single-port-write memory, so the
//   shift moves one entry per cycle. An accepted insert walks the entries
//   from the last down to its index and then writes the word; a delete reads
//   the removed word and walks the entries above it down; a refused request
//   goes straight to the response. The sequencer is idle from the edge that
//   loads the response register, so the next request is taken in the cycle after.
// Reset:
//   rst empties the list and drops any pending response; entry contents are
//   not cleared and no clearing pass is needed.
// Stalls:
//   While rsp_stall holds a response, one more request can still be taken and
//   worked on; its result then waits in the sequencer until the register frees.
module positional_list_insert_delete #(
  parameter int MAX_ENTRIES = pli_pkg::MAX_ENTRIES_DEF,
  parameter int ELEM_WIDTH  = pli_pkg::ELEM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          op,
  input  logic [pli_pkg::POS_W-1:0]     position,
  input  logic [pli_pkg::WORD_W-1:0]    payload,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [pli_pkg::STATUS_W-1:0]  status,
  output logic [pli_pkg::WORD_W-1:0]    removed,
  output logic [pli_pkg::COUNT_W-1:0]   count
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int FW = $clog2(MAX_ENTRIES + 1);

  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [ELEM_WIDTH-1:0]  rd_data;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [ELEM_WIDTH-1:0]  wr_data;
  logic                   res_valid;
  logic                   res_take;
  pli_pkg::res_t          res;

  pli_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ELEM_WIDTH  (ELEM_WIDTH),
    .AW          (AW),
    .FW          (FW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .op        (op),
    .position  (position),
    .payload   (payload),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  pli_mem #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (ELEM_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // response register loads when empty or being drained
  assign res_take = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= res_valid;
    end
  end

  // response word
  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      status  <= res.status;
      removed <= res.removed;
      count   <= res.count;
    end
  end

endmodule

/* design/pli_mem.sv */
// list entry store: one write port, one read port with registered read data
// no package dependencies
module pli_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/pli_seq.sv */
// sequencer: checks each request, walks the entry store to open or close a gap
// depends on pli_pkg; drives the ports of pli_mem
module pli_seq #(
  parameter int MAX_ENTRIES = pli_pkg::MAX_ENTRIES_DEF,
  parameter int ELEM_WIDTH  = pli_pkg::ELEM_WIDTH_DEF,
  parameter int AW          = $clog2(MAX_ENTRIES),
  parameter int FW          = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  // request side
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        op,
  input  logic [pli_pkg::POS_W-1:0]   position,
  input  logic [pli_pkg::WORD_W-1:0]  payload,
  // result side
  output logic                        res_valid,
  input  logic                        res_take,
  output pli_pkg::res_t               res,
  // entry store
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [ELEM_WIDTH-1:0]       rd_data,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [ELEM_WIDTH-1:0]       wr_data
);

  typedef enum logic [2:0] {
    IDLE,
    INS,
    PUT,
    DEL,
    DONE
  } state_t;

  state_t                 state;
  logic [FW-1:0]          fill;
  logic [AW-1:0]          ptr;
  logic [AW-1:0]          tgt;
  logic [ELEM_WIDTH-1:0]  word;
  logic                   first;

  logic                   acc;
  logic                   ins_full;
  logic                   ins_bad;
  logic                   del_bad;
  logic [AW-1:0]          idx;
  logic                   ins_at_end;

  assign req_stall = (state != IDLE);
  assign res_valid = (state == DONE);
  assign acc       = req_valid && (state == IDLE);

  // request checks
  assign ins_full   = 32'(fill) >= 32'(MAX_ENTRIES);
  assign ins_bad    = (32'(position) < 32'd1) || (32'(position) > 32'(fill) + 32'd1);
  assign del_bad    = (32'(position) < 32'd1) || (32'(position) > 32'(fill));
  assign idx        = AW'(position - 7'd1);
  assign ins_at_end = (FW'(idx) == fill);

  // entry store access
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state)
      IDLE: begin
        if (acc && op == pli_pkg::OP_INSERT && !ins_full && !ins_bad && !ins_at_end) begin
          rd_en   = 1'b1;
          rd_addr = AW'(fill - 1'b1);
        end
        if (acc && op == pli_pkg::OP_DELETE && !del_bad) begin
          rd_en   = 1'b1;
          rd_addr = idx;
        end
      end
      INS: begin
        // move one word up, fetch the one below it
        wr_en   = 1'b1;
        wr_addr = ptr + 1'b1;
        wr_data = rd_data;
        if (ptr != tgt) begin
          rd_en   = 1'b1;
          rd_addr = ptr - 1'b1;
        end
      end
      PUT: begin
        wr_en   = 1'b1;
        wr_addr = tgt;
        wr_data = word;
      end
      DEL: begin
        // move one word down, fetch the one above it
        if (!first) begin
          wr_en   = 1'b1;
          wr_addr = ptr - 1'b1;
          wr_data = rd_data;
        end
        if (FW'(ptr) < fill) begin
          rd_en   = 1'b1;
          rd_addr = ptr + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      fill  <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (acc) begin
            word        <= ELEM_WIDTH'(payload);
            tgt         <= idx;
            first       <= 1'b1;
            res.removed <= '0;
            res.count   <= pli_pkg::COUNT_W'(fill);
            if (op == pli_pkg::OP_INSERT) begin
              if (ins_full) begin
                res.status <= pli_pkg::ST_FULL;
                state      <= DONE;
              end else if (ins_bad) begin
                res.status <= pli_pkg::ST_RANGE;
                state      <= DONE;
              end else begin
                res.status <= pli_pkg::ST_OK;
                res.count  <= pli_pkg::COUNT_W'(fill + 1'b1);
                fill       <= fill + 1'b1;
                ptr        <= AW'(fill - 1'b1);
                state      <= ins_at_end ? PUT : INS;
              end
            end else begin
              if (del_bad) begin
                res.status <= pli_pkg::ST_RANGE;
                state      <= DONE;
              end else begin
                res.status <= pli_pkg::ST_OK;
                res.count  <= pli_pkg::COUNT_W'(fill - 1'b1);
                fill       <= fill - 1'b1;
                ptr        <= idx;
                state      <= DEL;
              end
            end
          end
        end
        INS: begin
          if (ptr == tgt) begin
            state <= PUT;
          end else begin
            ptr <= ptr - 1'b1;
          end
        end
        PUT: begin
          state <= DONE;
        end
        DEL: begin
          if (first) begin
            res.removed <= pli_pkg::WORD_W'(rd_data);
            first       <= 1'b0;
          end
          if (FW'(ptr) < fill) begin
            ptr <= ptr + 1'b1;
          end else begin
            state <= DONE;
          end
        end
        DONE: begin
          if (res_take) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
